>>> hdl/alr_pkg.sv
// Package for the audio linear resampler: configuration record, handshake
// control record, register indexes and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alr_pkg;

  localparam int RATE_W   = 17;
  localparam int PHASE_W  = 18;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] EMIT_CAP = 4'd12;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_STEREO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_STEREO = 2'd3;

  localparam logic [RATE_W-1:0] IN_RATE_RST  = 17'd44100;
  localparam logic [RATE_W-1:0] OUT_RATE_RST = 17'd16000;

  typedef struct packed {
    logic [RATE_W-1:0] in_rate;
    logic [RATE_W-1:0] out_rate;
    logic              input_stereo;
    logic              output_stereo;
  } alr_cfg_t;

  typedef struct packed {
    logic vld;
    logic last;
  } alr_push_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUSH,
    ST_NEXT,
    ST_FLUSH
  } alr_state_t;

endpackage

`default_nettype wire

>>> hdl/alr_div.sv
// Shared iterative divider: rounds |num|/den half away from zero, one
// quotient bit per cycle. Depends on alr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alr_div #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        start,
  input  wire logic signed [SAMPLE_WIDTH+alr_pkg::PHASE_W-1:0] num,
  input  wire logic [alr_pkg::RATE_W-1:0]                  den,
  output logic                                             done,
  output logic signed [SAMPLE_WIDTH-1:0]                   quot
);

  localparam int NW  = SAMPLE_WIDTH + alr_pkg::PHASE_W;
  localparam int IW  = $clog2(SAMPLE_WIDTH);
  localparam logic [IW-1:0] LAST_IT = IW'(SAMPLE_WIDTH - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          neg_r, neg_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dsh_r, dsh_nxt;
  logic [SAMPLE_WIDTH-1:0] quo_r, quo_nxt;
  logic [NW-1:0] mag;
  logic          ge;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign ge  = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    it_nxt   = it_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[NW-1];
      it_nxt   = '0;
      rem_nxt  = {mag[NW-2:0], 1'b0} + NW'(den);
      dsh_nxt  = NW'(den) << SAMPLE_WIDTH;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[SAMPLE_WIDTH-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      it_nxt  = it_r + 1'b1;
      if (it_r == LAST_IT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? signed'(-quo_r) : signed'(quo_r);

endmodule

`default_nettype wire

>>> hdl/alr_seq.sv
// Sequencer for the resampler: mono mix, phase stepping, shared multiplier
// and result hold-back for the last-word flag. Depends on alr_pkg, alr_div.
`timescale 1ns / 1ps
`default_nettype none

module alr_seq #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire alr_pkg::alr_cfg_t              cfg,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_right_sample,
  input  wire logic                           in_chunk_end,
  input  wire logic                           push_ok,
  output alr_pkg::alr_push_t                  push,
  output logic signed [SAMPLE_WIDTH-1:0]      push_sample
);

  localparam int NUMW = SAMPLE_WIDTH + alr_pkg::PHASE_W;
  localparam int PW   = alr_pkg::PHASE_W;
  localparam int RW   = alr_pkg::RATE_W;

  alr_pkg::alr_state_t state_r, state_nxt;

  logic signed [SAMPLE_WIDTH-1:0] held_r, held_nxt;
  logic                           held_vld_r, held_vld_nxt;
  logic [PW-1:0]                  phase_r, phase_nxt;
  logic signed [SAMPLE_WIDTH-1:0] a_r, a_nxt;
  logic signed [SAMPLE_WIDTH-1:0] b_r, b_nxt;
  logic                           end_r, end_nxt;
  logic                           tail_r, tail_nxt;
  logic [alr_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [NUMW-1:0]         acc_r, acc_nxt;
  logic signed [SAMPLE_WIDTH-1:0] pend_r, pend_nxt;
  logic                           pend_vld_r, pend_vld_nxt;

  logic signed [SAMPLE_WIDTH:0]   mix_sum;
  logic signed [SAMPLE_WIDTH-1:0] mono;
  logic signed [SAMPLE_WIDTH-1:0] mul_op;
  logic signed [RW:0]             mul_coef;
  logic signed [NUMW-1:0]         prod;
  logic [PW-1:0]                  out_rate_x;
  logic                           div_start, div_done;
  logic signed [SAMPLE_WIDTH-1:0] div_q;

  assign mix_sum = {in_left_sample[SAMPLE_WIDTH-1], in_left_sample}
                 + {in_right_sample[SAMPLE_WIDTH-1], in_right_sample};
  assign mono    = cfg.input_stereo ? mix_sum[SAMPLE_WIDTH:1] : in_left_sample;

  assign out_rate_x = {1'b0, cfg.out_rate};

  assign mul_op   = (state_r == alr_pkg::ST_MUL_B) ? b_r : a_r;
  assign mul_coef = (state_r == alr_pkg::ST_MUL_B) ? signed'({1'b0, phase_r[RW-1:0]})
                  : signed'({1'b0, cfg.out_rate - phase_r[RW-1:0]});
  assign prod     = NUMW'(mul_op) * NUMW'(mul_coef);

  alr_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (cfg.out_rate),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    phase_nxt    = phase_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    end_nxt      = end_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    push         = '0;
    push_sample  = pend_r;
    div_start    = 1'b0;
    unique case (state_r)
      alr_pkg::ST_IDLE: begin
        if (in_valid) begin
          held_nxt     = mono;
          held_vld_nxt = 1'b1;
          end_nxt      = in_chunk_end;
          cnt_nxt      = '0;
          b_nxt        = mono;
          if (held_vld_r) begin
            a_nxt     = held_r;
            tail_nxt  = 1'b0;
            state_nxt = alr_pkg::ST_CHECK;
          end else begin
            phase_nxt = '0;
            a_nxt     = mono;
            tail_nxt  = 1'b1;
            if (in_chunk_end) begin
              state_nxt = alr_pkg::ST_CHECK;
            end
          end
        end
      end
      alr_pkg::ST_CHECK: begin
        if (phase_r < out_rate_x) begin
          if (cnt_r == alr_pkg::EMIT_CAP) begin
            phase_nxt = out_rate_x;
            state_nxt = alr_pkg::ST_NEXT;
          end else begin
            state_nxt = alr_pkg::ST_MUL_A;
          end
        end else begin
          state_nxt = alr_pkg::ST_NEXT;
        end
      end
      alr_pkg::ST_MUL_A: begin
        acc_nxt   = prod;
        state_nxt = alr_pkg::ST_MUL_B;
      end
      alr_pkg::ST_MUL_B: begin
        acc_nxt   = acc_r + prod;
        state_nxt = alr_pkg::ST_DIV_GO;
      end
      alr_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = alr_pkg::ST_DIV_WAIT;
      end
      alr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = alr_pkg::ST_PUSH;
        end
      end
      alr_pkg::ST_PUSH: begin
        push.vld = pend_vld_r;
        if (!pend_vld_r || push_ok) begin
          pend_nxt     = div_q;
          pend_vld_nxt = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          phase_nxt    = phase_r + PW'(cfg.in_rate);
          state_nxt    = alr_pkg::ST_CHECK;
        end
      end
      alr_pkg::ST_NEXT: begin
        if (!tail_r) begin
          phase_nxt = phase_r - out_rate_x;
          if (end_r) begin
            a_nxt     = b_r;
            tail_nxt  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = alr_pkg::ST_CHECK;
          end else begin
            state_nxt = alr_pkg::ST_FLUSH;
          end
        end else begin
          held_nxt     = '0;
          held_vld_nxt = 1'b0;
          phase_nxt    = '0;
          state_nxt    = alr_pkg::ST_FLUSH;
        end
      end
      alr_pkg::ST_FLUSH: begin
        push.vld  = pend_vld_r;
        push.last = 1'b1;
        if (!pend_vld_r) begin
          state_nxt = alr_pkg::ST_IDLE;
        end else if (push_ok) begin
          pend_vld_nxt = 1'b0;
          state_nxt    = alr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = alr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= alr_pkg::ST_IDLE;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      phase_r    <= '0;
      end_r      <= 1'b0;
      tail_r     <= 1'b0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      phase_r    <= phase_nxt;
      end_r      <= end_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    pend_r <= pend_nxt;
  end

  assign in_stall = (state_r != alr_pkg::ST_IDLE);

endmodule

`default_nettype wire

>>> hdl/audio_linear_resampler_unit.sv
// Top level of the audio linear resampler: configuration registers, output
// word register and the sequencer. Depends on alr_pkg, alr_seq.
// Each result passes through the shared bit-serial divider; output stalls lengthen it.
// A frame gives n results; when it follows a held sample and ends the chunk it also runs a
// tail pass on that sample; a chunk's first frame that does not end it is only held.
// One frame at a time, up to 24 results. Reset restores rates, clears held sample and phase.
`timescale 1ns / 1ps
`default_nettype none

module audio_linear_resampler_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [alr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [alr_pkg::RATE_W-1:0]          cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_left_sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_right_sample,
  input  wire logic                                in_chunk_end,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           out_pcm,
  output logic                                     out_duplicate,
  output logic                                     out_run_last
);

  alr_pkg::alr_cfg_t  cfg_r, cfg_nxt;
  alr_pkg::alr_push_t push;
  logic signed [SAMPLE_WIDTH-1:0] push_sample;
  logic push_ok;

  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_pcm_r, out_pcm_nxt;
  logic                           out_dup_r, out_dup_nxt;
  logic                           out_last_r, out_last_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        alr_pkg::CFG_IN_RATE:       cfg_nxt.in_rate       = cfg_wdata;
        alr_pkg::CFG_OUT_RATE:      cfg_nxt.out_rate      = cfg_wdata;
        alr_pkg::CFG_INPUT_STEREO:  cfg_nxt.input_stereo  = cfg_wdata[0];
        alr_pkg::CFG_OUTPUT_STEREO: cfg_nxt.output_stereo = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  alr_seq #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_chunk_end    (in_chunk_end),
    .push_ok         (push_ok),
    .push            (push),
    .push_sample     (push_sample)
  );

  assign push_ok = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pcm_nxt   = out_pcm_r;
    out_dup_nxt   = out_dup_r;
    out_last_nxt  = out_last_r;
    if (push_ok) begin
      out_valid_nxt = push.vld;
      if (push.vld) begin
        out_pcm_nxt  = push_sample;
        out_dup_nxt  = cfg_r.output_stereo;
        out_last_nxt = push.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_rate       <= alr_pkg::IN_RATE_RST;
      cfg_r.out_rate      <= alr_pkg::OUT_RATE_RST;
      cfg_r.input_stereo  <= 1'b1;
      cfg_r.output_stereo <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_pcm_r  <= out_pcm_nxt;
    out_dup_r  <= out_dup_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pcm       = out_pcm_r;
  assign out_duplicate = out_dup_r;
  assign out_run_last  = out_last_r;

endmodule

`default_nettype wire

>>> hdl/alr_checker.sv
// Port-level checks for the audio linear resampler, bound to the top level.
// Depends on audio_linear_resampler_unit.
`timescale 1ns / 1ps
`default_nettype none

module alr_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_chunk_end,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_pcm,
  input wire logic                           out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pcm) && $stable(out_run_last))
    else $error("stalled output word changed");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_chunk_end |=> in_stall)
    else $error("chunk end word did not start the tail pass");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid after reset");

endmodule

bind audio_linear_resampler_unit alr_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_alr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_chunk_end (in_chunk_end),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_pcm      (out_pcm),
  .out_run_last (out_run_last)
);

`default_nettype wire
